>>> rtl/core/gic_pkg.sv
// Shared types and register codes for the GPIO interrupt controller.
`default_nettype none

package gic_pkg;

    localparam int DATA_WIDTH = 8;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects
    localparam logic [2:0] SEL_ENABLE   = 3'd0;
    localparam logic [2:0] SEL_MASK     = 3'd1;
    localparam logic [2:0] SEL_TYPE     = 3'd2;
    localparam logic [2:0] SEL_POLARITY = 3'd3;
    localparam logic [2:0] SEL_STATUS   = 3'd4;
    localparam logic [2:0] SEL_EOI      = 3'd5;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [DATA_WIDTH-1:0] pin_levels;
        logic [2:0]            reg_select;
        logic [DATA_WIDTH-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq_line;
    } out_item_t;

    // What one pin lane reports to the merge stage
    typedef struct packed {
        logic enable;
        logic mask;
        logic edge_mode;
        logic polarity;
        logic status_now;
        logic status_next;
    } lane_state_t;

endpackage

`default_nettype wire

>>> rtl/core/gpio_interrupt_controller_top.sv
// Top level of the GPIO interrupt controller: pin lanes, merge and output register.
//
//  Channel | Dir | Handshake          | Payload
//  s_      | in  | s_valid / s_ready  | s_item : tick, register read or register write
//  m_      | out | m_valid / m_ready  | m_item : read data and interrupt line
//
// One item per clock while s_ready is high; its result is loaded into the output register on accept.
// The result path has a single output register behind the lane logic and merge.
// s_ready is high whenever the output register is empty or being drained this cycle.
// aresetn (synchronous, active low) clears all lane registers and the output valid.
// A stalled result holds in the output register; the lanes hold state until accept.
`default_nettype none

module gpio_interrupt_controller_top #(
    parameter int PIN_COUNT = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire gic_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output gic_pkg::out_item_t     m_item
);

    // Only the low eight pins reach the bus fields
    localparam int LANE_COUNT = (PIN_COUNT < gic_pkg::DATA_WIDTH) ? PIN_COUNT
                                                                  : gic_pkg::DATA_WIDTH;

    gic_pkg::lane_state_t  lane_state [LANE_COUNT];
    gic_pkg::out_item_t    result;
    gic_pkg::out_item_t    m_item_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  accept;
    logic [LANE_COUNT-1:0] enable_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // One lane per pin, all updating on the same accepted item
    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        gic_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .accept     (accept),
            .opcode     (s_item.opcode),
            .reg_select (s_item.reg_select),
            .pin_level  (s_item.pin_levels[g]),
            .data_bit   (s_item.write_data[g]),
            .lane_state (lane_state[g])
        );
        assign enable_vec[g] = lane_state[g].enable;
    end

    // Combine lane results into one result item
    gic_merge #(
        .LANE_COUNT (LANE_COUNT)
    ) u_merge (
        .opcode     (s_item.opcode),
        .reg_select (s_item.reg_select),
        .lane_state (lane_state),
        .result     (result)
    );

    // Output register: load on accept, drop valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A read of the enable register returns the lane enables as they stood
    a_read_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.opcode == gic_pkg::OP_READ
               && s_item.reg_select == gic_pkg::SEL_ENABLE
        |=> m_item.read_data == gic_pkg::DATA_WIDTH'($past(enable_vec)))
        else $error("enable read mismatch");

    // Disabling every pin silences the interrupt line for that item
    a_disable_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.opcode == gic_pkg::OP_WRITE
               && s_item.reg_select == gic_pkg::SEL_ENABLE
               && s_item.write_data[LANE_COUNT-1:0] == '0
        |=> !m_item.irq_line)
        else $error("interrupt raised with all pins disabled");

endmodule

`default_nettype wire

>>> rtl/core/gic_lane.sv
// Per-pin interrupt lane: configuration bits, edge latch and previous sample.
`default_nettype none

module gic_lane (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [1:0]         opcode,
    input  wire logic [2:0]         reg_select,
    input  wire logic               pin_level,
    input  wire logic               data_bit,
    output gic_pkg::lane_state_t    lane_state
);

    logic enable_reg,   enable_next;
    logic mask_reg,     mask_next;
    logic edge_reg,     edge_next;
    logic polarity_reg, polarity_next;
    logic latch_reg,    latch_next;
    logic prev_reg,     prev_next;
    logic hit;

    always_comb begin
        enable_next   = enable_reg;
        mask_next     = mask_reg;
        edge_next     = edge_reg;
        polarity_next = polarity_reg;
        latch_next    = latch_reg;
        prev_next     = prev_reg;
        hit = polarity_reg ? (pin_level & ~prev_reg) : (~pin_level & prev_reg);
        case (opcode)
            gic_pkg::OP_TICK: begin
                latch_next = latch_reg | (hit & edge_reg & enable_reg);
                prev_next  = pin_level;
            end
            gic_pkg::OP_WRITE: begin
                case (reg_select)
                    gic_pkg::SEL_ENABLE:   enable_next   = data_bit;
                    gic_pkg::SEL_MASK:     mask_next     = data_bit;
                    gic_pkg::SEL_TYPE:     edge_next     = data_bit;
                    gic_pkg::SEL_POLARITY: polarity_next = data_bit;
                    gic_pkg::SEL_EOI:      latch_next    = latch_reg & ~data_bit;
                    default: ;
                endcase
            end
            default: ;
        endcase
        // drop stale latches of pins not enabled or not in edge mode
        latch_next = latch_next & edge_next & enable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            mask_reg     <= 1'b0;
            edge_reg     <= 1'b0;
            polarity_reg <= 1'b0;
            latch_reg    <= 1'b0;
            prev_reg     <= 1'b0;
        end else if (accept) begin
            enable_reg   <= enable_next;
            mask_reg     <= mask_next;
            edge_reg     <= edge_next;
            polarity_reg <= polarity_next;
            latch_reg    <= latch_next;
            prev_reg     <= prev_next;
        end
    end

    always_comb begin
        lane_state.enable      = enable_reg;
        lane_state.mask        = mask_reg;
        lane_state.edge_mode   = edge_reg;
        lane_state.polarity    = polarity_reg;
        lane_state.status_now  = (edge_reg ? latch_reg : ~(prev_reg ^ polarity_reg))
                                 & enable_reg & ~mask_reg;
        lane_state.status_next = (edge_next ? latch_next : ~(prev_next ^ polarity_next))
                                 & enable_next & ~mask_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/gic_merge.sv
// Merge stage: read-data select across lanes and OR of the status bits.
`default_nettype none

module gic_merge #(
    parameter int LANE_COUNT = 8
) (
    input  wire logic [1:0]          opcode,
    input  wire logic [2:0]          reg_select,
    input  wire gic_pkg::lane_state_t lane_state [LANE_COUNT],
    output gic_pkg::out_item_t       result
);

    logic [LANE_COUNT-1:0] enable_vec;
    logic [LANE_COUNT-1:0] mask_vec;
    logic [LANE_COUNT-1:0] edge_vec;
    logic [LANE_COUNT-1:0] polarity_vec;
    logic [LANE_COUNT-1:0] status_vec;
    logic [LANE_COUNT-1:0] status_next_vec;
    logic [LANE_COUNT-1:0] sel_vec;

    always_comb begin
        for (int i = 0; i < LANE_COUNT; i++) begin
            enable_vec[i]      = lane_state[i].enable;
            mask_vec[i]        = lane_state[i].mask;
            edge_vec[i]        = lane_state[i].edge_mode;
            polarity_vec[i]    = lane_state[i].polarity;
            status_vec[i]      = lane_state[i].status_now;
            status_next_vec[i] = lane_state[i].status_next;
        end
        sel_vec = '0;
        if (opcode == gic_pkg::OP_READ) begin
            case (reg_select)
                gic_pkg::SEL_ENABLE:   sel_vec = enable_vec;
                gic_pkg::SEL_MASK:     sel_vec = mask_vec;
                gic_pkg::SEL_TYPE:     sel_vec = edge_vec;
                gic_pkg::SEL_POLARITY: sel_vec = polarity_vec;
                gic_pkg::SEL_STATUS:   sel_vec = status_vec;
                default:               sel_vec = '0;
            endcase
        end
        result.read_data = gic_pkg::DATA_WIDTH'(sel_vec);
        result.irq_line  = |status_next_vec;
    end

endmodule

`default_nettype wire

>>> tb/tb_gpio_interrupt_controller_top.sv
// Self-checking testbench for the GPIO interrupt controller top level.
module tb_gpio_interrupt_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gic_pkg::*;

    // Codes the package leaves unnamed but the fields can still carry
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam logic [2:0] SEL_SPARE6 = 3'd6;
    localparam logic [2:0] SEL_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 450;
    localparam int PHASE_LEN    = 50;
    localparam int HOLD_CYCLES  = 64;
    localparam int HOLD_AT      = 40;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // Idling regimes, cycled through the random part
    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } idle_phase_t;

    typedef struct packed {
        in_item_t    item;
        idle_phase_t phase;
    } pending_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    pending_item_t items_to_send[$];
    out_item_t     irq_results_due[$];
    pending_item_t next_req;
    idle_phase_t   cur_phase = PH_FREE;

    logic s_took = 1'b0;
    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_errors = 0;
    int   cycle_count = 0;
    int   hold_left = 0;
    bit   hold_used = 1'b0;

    // Predictor state: one copy of every register the block keeps
    logic [DATA_WIDTH-1:0] en_bits;
    logic [DATA_WIDTH-1:0] msk_bits;
    logic [DATA_WIDTH-1:0] edge_sel;
    logic [DATA_WIDTH-1:0] pol_bits;
    logic [DATA_WIDTH-1:0] edge_hits;
    logic [DATA_WIDTH-1:0] last_pins;

    gpio_interrupt_controller_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Pending-and-enabled-and-unmasked pins, from the current predictor state
    function automatic logic [DATA_WIDTH-1:0] active_pins();
        logic [DATA_WIDTH-1:0] level_hit;
        logic [DATA_WIDTH-1:0] pending;
        level_hit = ~(last_pins ^ pol_bits);
        pending   = (edge_hits & edge_sel) | (level_hit & ~edge_sel);
        return pending & en_bits & ~msk_bits;
    endfunction

    // Advance the predictor by one item and return the result it must produce
    function automatic out_item_t predict_irq_result(in_item_t it);
        out_item_t             res;
        logic [DATA_WIDTH-1:0] hit;
        res = '0;
        case (it.opcode)
            OP_TICK: begin
                // rising edges count for polarity 1, falling edges for polarity 0
                hit = (it.pin_levels & ~last_pins & pol_bits)
                    | (~it.pin_levels & last_pins & ~pol_bits);
                edge_hits = edge_hits | (hit & edge_sel & en_bits);
                last_pins = it.pin_levels;
            end
            OP_READ: begin
                case (it.reg_select)
                    SEL_ENABLE:   res.read_data = en_bits;
                    SEL_MASK:     res.read_data = msk_bits;
                    SEL_TYPE:     res.read_data = edge_sel;
                    SEL_POLARITY: res.read_data = pol_bits;
                    SEL_STATUS:   res.read_data = active_pins();
                    default:      res.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (it.reg_select)
                    SEL_ENABLE:   en_bits = it.write_data;
                    SEL_MASK:     msk_bits = it.write_data;
                    SEL_TYPE:     edge_sel = it.write_data;
                    SEL_POLARITY: pol_bits = it.write_data;
                    SEL_EOI:      edge_hits = edge_hits & ~it.write_data;
                    default:      ;
                endcase
            end
            default: ;
        endcase
        // latches only survive on enabled edge-mode pins
        edge_hits = edge_hits & edge_sel & en_bits;
        res.irq_line = |active_pins();
        return res;
    endfunction

    function automatic bit sender_idles(idle_phase_t ph);
        if (ph == PH_SEND_IDLE) return $urandom_range(99) < 45;
        if (ph == PH_BOTH) return $urandom_range(99) < 17;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls(idle_phase_t ph);
        if (ph == PH_RECV_STALL) return $urandom_range(99) < 45;
        if (ph == PH_BOTH) return $urandom_range(99) < 17;
        return 1'b0;
    endfunction

    task automatic queue_item(logic [1:0] op, logic [7:0] pins, logic [2:0] sel,
                              logic [7:0] data, idle_phase_t ph);
        pending_item_t p;
        p.item.opcode     = op;
        p.item.pin_levels = pins;
        p.item.reg_select = sel;
        p.item.write_data = data;
        p.phase           = ph;
        items_to_send.push_back(p);
        n_queued++;
    endtask

    // Pick a random item: mostly ticks and register traffic, a little noise
    task automatic queue_random_item(idle_phase_t ph);
        int          roll;
        logic [1:0]  op;
        logic [2:0]  sel;
        roll = $urandom_range(99);
        if (roll < 45)      op = OP_TICK;
        else if (roll < 65) op = OP_READ;
        else if (roll < 95) op = OP_WRITE;
        else                op = OP_SPARE;
        // spare selects are rare; the real registers get the bulk
        if ($urandom_range(99) < 8) sel = 3'($urandom_range(7, 6));
        else                        sel = 3'($urandom_range(5));
        queue_item(op, 8'($urandom_range(255)), sel, 8'($urandom_range(255)), ph);
    endtask

    // Reset, stimulus and the final verdict
    initial begin
        en_bits   = '0;
        msk_bits  = '0;
        edge_sel  = '0;
        pol_bits  = '0;
        edge_hits = '0;
        last_pins = '0;

        // Directed part: read enable, status, end-of-interrupt and a spare select out of reset
        queue_item(OP_READ,  8'h00, SEL_ENABLE,   8'h00, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_STATUS,   8'h00, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_EOI,      8'h00, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_SPARE7,   8'h00, PH_FREE);
        // Enable all pins: level-low pins fire at once since the sample is zero
        queue_item(OP_WRITE, 8'h00, SEL_ENABLE,   8'hFF, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_TYPE,     8'h0F, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_POLARITY, 8'h55, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_TYPE,     8'h00, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_POLARITY, 8'h00, PH_FREE);
        // Drive all-high then all-low so both rising and falling latches set
        queue_item(OP_TICK,  8'hFF, SEL_ENABLE,   8'h00, PH_FREE);
        queue_item(OP_TICK,  8'h00, SEL_ENABLE,   8'h00, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_STATUS,   8'h00, PH_FREE);
        // Partial end-of-interrupt, then clear the rest
        queue_item(OP_WRITE, 8'h00, SEL_EOI,      8'h05, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_STATUS,   8'h00, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_EOI,      8'hFF, PH_FREE);
        // Writes to status and spare selects, and a spare opcode, must be ignored
        queue_item(OP_WRITE, 8'h00, SEL_STATUS,   8'hFF, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_SPARE6,   8'hFF, PH_FREE);
        queue_item(OP_SPARE, 8'hFF, SEL_ENABLE,   8'hFF, PH_FREE);
        // Mask everything, then unmask, then drop enable to flush latches
        queue_item(OP_TICK,  8'hAA, SEL_ENABLE,   8'h00, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_MASK,     8'hFF, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_MASK,     8'h00, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_MASK,     8'h00, PH_FREE);
        queue_item(OP_TICK,  8'h55, SEL_ENABLE,   8'h00, PH_FREE);
        queue_item(OP_WRITE, 8'h00, SEL_ENABLE,   8'h00, PH_FREE);
        queue_item(OP_READ,  8'h00, SEL_STATUS,   8'h00, PH_FREE);

        // Random part: idling regime changes every PHASE_LEN items
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            queue_random_item(idle_phase_t'((i / PHASE_LEN) % 4));
        end

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every item to go in and every result to come back
        do begin
            @(posedge aclk);
        end while (n_accepted != n_queued || irq_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Driver: hold an offered item until it is taken, then advance
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            // hold payload and valid
        end else if (items_to_send.size() != 0 && !sender_idles(items_to_send[0].phase)) begin
            next_req  = items_to_send.pop_front();
            s_item    <= next_req.item;
            s_valid   <= 1'b1;
            cur_phase <= next_req.phase;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: one long hold-off early on to back up the block, then random stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_accepted >= HOLD_AT) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !receiver_stalls(cur_phase);
        end
    end

    // Monitor: check results against the oldest prediction, then record new input items
    always @(posedge aclk) begin
        out_item_t want;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (irq_results_due.size() == 0) begin
                    $error("result with nothing expected: read_data %0h irq_line %0b",
                           m_item.read_data, m_item.irq_line);
                    n_errors++;
                end else begin
                    want = irq_results_due.pop_front();
                    if (m_item.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, actual %0h",
                               want.read_data, m_item.read_data);
                        n_errors++;
                    end
                    if (m_item.irq_line !== want.irq_line) begin
                        $error("irq_line: expected %0b, actual %0b",
                               want.irq_line, m_item.irq_line);
                        n_errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                irq_results_due.push_back(predict_irq_result(s_item));
                n_accepted++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
